// ===== rtl/core/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int OFFSET_W        = 32;
  localparam int RESULT_OFF_W    = 34;
  localparam int ADDRESS_W       = 64;
  localparam int PATTERN_WORDS   = 4;
  localparam int PATTERN_REG_BYTES = 32;
  localparam int REL_FIELD_BYTES = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_0   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_1   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_2   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_3   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISP_OFFSET = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_BASE  = 3'd7;

  // Relative-resolution controls derived from the configuration
  typedef struct packed {
    logic                    rel_en;
    logic [RESULT_OFF_W-1:0] adj;
  } wbps_rel_t;

endpackage

// ===== rtl/core/wbps_if.sv =====
// Handshake channels of the scanner: input bytes, results and configuration writes.
interface wbps_in_if;
  logic                              valid;
  logic                              ready;
  logic [7:0]                        data_byte;
  logic [wbps_pkg::OFFSET_W-1:0]     byte_offset;
  logic                              section_first;
  logic                              section_last;

  modport source (output valid, data_byte, byte_offset, section_first, section_last,
                  input ready);
  modport sink (input valid, data_byte, byte_offset, section_first, section_last,
                output ready);
endinterface

interface wbps_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  found;
  logic signed [wbps_pkg::RESULT_OFF_W-1:0] resolved_offset;
  logic [wbps_pkg::ADDRESS_W-1:0]        resolved_address;

  modport source (output valid, found, resolved_offset, resolved_address, input ready);
  modport sink (input valid, found, resolved_offset, resolved_address, output ready);
endinterface

interface wbps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wbps_pkg::CFG_INDEX_W-1:0] index;
  logic [wbps_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wbps_align.sv =====
// Aligns the configured pattern to window positions and derives the relative-mode controls.
module wbps_align #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic [wbps_pkg::PATTERN_WORDS-1:0][63:0]      pattern_word,
  input  logic [wbps_pkg::PATTERN_REG_BYTES-1:0]        care_mask,
  input  logic [5:0]                                    pattern_length,
  input  logic [5:0]                                    disp_offset,
  output logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]        eff_len,
  output logic [MAX_PATTERN_BYTES-1:0]                  acare,
  output logic [MAX_PATTERN_BYTES-1:0][7:0]             apat,
  output logic [$clog2(MAX_PATTERN_BYTES)-1:0]          rel_pos,
  output wbps_pkg::wbps_rel_t                           rel
);

  localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IW = $clog2(MAX_PATTERN_BYTES);
  localparam int OW = wbps_pkg::RESULT_OFF_W;

  logic [wbps_pkg::PATTERN_REG_BYTES-1:0][7:0] pat_bytes;
  logic [6:0] len7;
  logic [6:0] len_clamp;
  logic [6:0] pos7;
  logic       rel_en;

  assign pat_bytes = pattern_word;

  // Clamp the length to 1..MAX_PATTERN_BYTES
  assign len7 = {1'b0, pattern_length};
  always_comb begin
    if (len7 == 7'd0) begin
      len_clamp = 7'd1;
    end else if (len7 > 7'(MAX_PATTERN_BYTES)) begin
      len_clamp = 7'(MAX_PATTERN_BYTES);
    end else begin
      len_clamp = len7;
    end
  end
  assign eff_len = LW'(len_clamp);

  // Window position k holds match byte eff_len-1-k; bytes without a register are wildcards
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_pos
    logic [7:0] idx;
    logic       in_use;
    assign idx    = {1'b0, len_clamp} - 8'(k + 1);
    assign in_use = (8'(k) < {1'b0, len_clamp}) &&
                    (idx < 8'(wbps_pkg::PATTERN_REG_BYTES));
    assign acare[k] = in_use & care_mask[idx[4:0]];
    assign apat[k]  = pat_bytes[idx[4:0]];
  end

  // Relative field must lie wholly inside the match
  assign rel_en  = !disp_offset[5] &&
                   ({2'b00, disp_offset[4:0]} + 7'(wbps_pkg::REL_FIELD_BYTES) <= len_clamp);
  assign pos7    = len_clamp - 7'd1 - {2'b00, disp_offset[4:0]};
  assign rel_pos = pos7[IW-1:0];

  // Constant part of the result: -(len-1), plus offset+4 in relative mode
  assign rel.rel_en = rel_en;
  assign rel.adj    = (rel_en ? OW'(disp_offset[4:0]) + OW'(wbps_pkg::REL_FIELD_BYTES)
                              : OW'(0))
                      - OW'(len_clamp) + OW'(1);

endmodule

// ===== rtl/core/wildcard_byte_pattern_scan.sv =====
// Top level of the wildcard byte pattern scanner.
// Takes one section byte per cycle while input ready is high and reports the first
// wildcard pattern match in each section (or one miss at the section's end). A byte is
// captured into the byte window on acceptance; once the result register is free, every
// window position is compared in parallel with the aligned pattern and the hit, offset
// and address are registered into the result register. The window and the result
// register form a two-deep pipeline: input ready drops only while the result register
// holds an untaken result and the window stage is full. Configuration writes are always
// accepted and take effect on the next window evaluation.
module wildcard_byte_pattern_scan #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  wbps_cfg_if.sink          cfg,
  wbps_in_if.sink           scan,
  wbps_out_if.source        result
);

  localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int IW = $clog2(MAX_PATTERN_BYTES);
  localparam int OW = wbps_pkg::RESULT_OFF_W;
  localparam int AW = wbps_pkg::ADDRESS_W;

  // Configuration registers
  logic [wbps_pkg::PATTERN_WORDS-1:0][63:0] pattern_word;
  logic [31:0]                              care_mask;
  logic [5:0]                               pattern_length;
  logic [5:0]                               disp_offset;
  logic [AW-1:0]                            image_base;

  // Window stage
  logic [7:0]                         win [MAX_PATTERN_BYTES];
  logic [LW-1:0]                      fill;
  logic                               p_valid;
  logic                               p_first;
  logic                               p_last;
  logic [wbps_pkg::OFFSET_W-1:0]      p_offset;

  // Result stage
  logic                               section_hit;
  logic                               out_valid;
  logic                               out_found;
  logic [OW-1:0]                      out_offset;
  logic [AW-1:0]                      out_address;

  // Aligned pattern
  logic [LW-1:0]                      eff_len;
  logic [MAX_PATTERN_BYTES-1:0]       acare;
  logic [MAX_PATTERN_BYTES-1:0][7:0]  apat;
  logic [IW-1:0]                      rel_pos;
  wbps_pkg::wbps_rel_t                rel;

  logic                               out_free;
  logic                               advance;
  logic                               in_take;
  logic                               ev;
  logic [MAX_PATTERN_BYTES-1:0]       pos_ok;
  logic                               match;
  logic                               hit_prev;
  logic                               hit_now;
  logic                               produce;
  logic [31:0]                        raw;
  logic [OW-1:0]                      res;
  logic [OW-1:0]                      res_next;
  logic [AW-1:0]                      addr_next;

  wbps_align #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_align (
    .pattern_word   (pattern_word),
    .care_mask      (care_mask),
    .pattern_length (pattern_length),
    .disp_offset    (disp_offset),
    .eff_len        (eff_len),
    .acare          (acare),
    .apat           (apat),
    .rel_pos        (rel_pos),
    .rel            (rel)
  );

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_word   <= '0;
      care_mask      <= '0;
      pattern_length <= 6'd1;
      disp_offset    <= 6'h3F;
      image_base     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        wbps_pkg::CFG_PATTERN_0:   pattern_word[0] <= cfg.data;
        wbps_pkg::CFG_PATTERN_1:   pattern_word[1] <= cfg.data;
        wbps_pkg::CFG_PATTERN_2:   pattern_word[2] <= cfg.data;
        wbps_pkg::CFG_PATTERN_3:   pattern_word[3] <= cfg.data;
        wbps_pkg::CFG_CARE_MASK:   care_mask       <= cfg.data[31:0];
        wbps_pkg::CFG_PATTERN_LEN: pattern_length  <= cfg.data[5:0];
        wbps_pkg::CFG_DISP_OFFSET: disp_offset     <= cfg.data[5:0];
        wbps_pkg::CFG_IMAGE_BASE:  image_base      <= cfg.data;
        default: ;
      endcase
    end
  end

  // Handshake: the window stage advances when its request can move on
  assign out_free    = !out_valid || result.ready;
  assign advance     = !p_valid || out_free;
  assign scan.ready  = advance;
  assign in_take     = scan.valid && advance;
  assign ev          = p_valid && out_free;

  // Shift the byte into the window
  always_ff @(posedge clk) begin
    if (in_take) begin
      win[0] <= scan.data_byte;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
        win[k] <= win[k-1];
      end
      p_offset <= scan.byte_offset;
    end
  end

  // Window fill and stage control; restart after a section boundary
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_first <= 1'b0;
      p_last  <= 1'b0;
      fill    <= '0;
    end else begin
      if (advance) begin
        p_valid <= scan.valid;
      end
      if (in_take) begin
        p_first <= scan.section_first;
        p_last  <= scan.section_last;
        if (scan.section_first || p_last) begin
          fill <= LW'(1);
        end else if (fill != LW'(MAX_PATTERN_BYTES)) begin
          fill <= fill + LW'(1);
        end
      end
    end
  end

  // Compare every window position in parallel
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cmp
    assign pos_ok[k] = !acare[k] || (win[k] == apat[k]);
  end
  assign match = (&pos_ok) && (fill >= eff_len);

  assign hit_prev = section_hit && !p_first;
  assign hit_now  = !hit_prev && match;
  assign produce  = hit_now || (p_last && !hit_prev);

  // Gather the little-endian displacement from the window
  assign raw = {win[rel_pos - IW'(3)], win[rel_pos - IW'(2)],
                win[rel_pos - IW'(1)], win[rel_pos]};

  // Resolve offset and address
  assign res       = OW'(p_offset) + rel.adj +
                     (rel.rel_en ? {{(OW-32){raw[31]}}, raw} : OW'(0));
  assign res_next  = hit_now ? res : OW'(0);
  assign addr_next = hit_now ? image_base + {{(AW-OW){res[OW-1]}}, res} : AW'(0);

  // Result register and first-hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      section_hit <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= ev && produce;
      end
      if (ev) begin
        section_hit <= !p_last && (hit_prev || hit_now);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev) begin
      out_found   <= hit_now;
      out_offset  <= res_next;
      out_address <= addr_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.found            = out_found;
  assign result.resolved_offset  = $signed(out_offset);
  assign result.resolved_address = out_address;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LW'(MAX_PATTERN_BYTES))
    else $error("window fill above capacity");

  a_first_restart: assert property (@(posedge clk) disable iff (rst)
    (scan.valid && scan.ready && scan.section_first) |=> (fill == LW'(1)))
    else $error("window not restarted on section start");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (ev && p_last) |=> !section_hit)
    else $error("hit flag survives section end");

  a_one_per_eval: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !ev)
    else $error("result stage overwritten while stalled");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the wildcard byte pattern scanner: directed and random sections.
`timescale 1ns / 1ps

module tb_top;

  localparam int WINDOW_BYTES = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BYTES = 60;

  typedef struct {
    logic                              found;
    logic [wbps_pkg::RESULT_OFF_W-1:0] res_offset;
    logic [wbps_pkg::ADDRESS_W-1:0]    res_address;
  } scan_report_t;

  typedef struct {
    logic [wbps_pkg::PATTERN_WORDS*64-1:0] pattern;
    logic [31:0]                           care;
    logic [5:0]                            length;
    logic [5:0]                            disp;
    logic [wbps_pkg::ADDRESS_W-1:0]        base;
  } scan_setting_t;

  logic clk = 1'b0;
  logic rst;

  wbps_cfg_if cfg_ch ();
  wbps_in_if  scan_ch ();
  wbps_out_if result_ch ();

  wildcard_byte_pattern_scan u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .scan   (scan_ch),
    .result (result_ch)
  );

  // Scanner model state and its copy of the registers
  logic [wbps_pkg::PATTERN_WORDS*64-1:0] pat_bytes = '0;
  logic [31:0]                           care_bits = '0;
  logic [5:0]                            len_reg = 6'd1;
  logic [5:0]                            disp_reg = 6'h3F;
  logic [wbps_pkg::ADDRESS_W-1:0]        base_reg = '0;
  logic [7:0]                            match_window [WINDOW_BYTES];
  int                                    window_count = 0;
  bit                                    section_matched = 1'b0;

  scan_report_t expected_reports [$];
  int           fail_count = 0;
  int           burst_left = 0;
  int           long_hold_req = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp the length register to the span the scanner really compares
  function automatic int span_of(input logic [5:0] len);
    if (len == 6'd0) return 1;
    if (len > WINDOW_BYTES) return WINDOW_BYTES;
    return int'(len);
  endfunction

  // Shift one accepted byte into the window and queue the report it causes
  task automatic predict_scan_byte(input logic [7:0] data, input logic [31:0] offs,
                                   input logic first, input logic last);
    int                                span;
    int                                d;
    int                                k;
    bit                                ok;
    logic [63:0]                       start;
    logic [31:0]                       raw;
    logic [wbps_pkg::RESULT_OFF_W-1:0] off34;
    scan_report_t                      rep;
    span = span_of(len_reg);
    if (first) begin
      window_count = 0;
      section_matched = 1'b0;
    end
    for (k = WINDOW_BYTES - 1; k > 0; k--) match_window[k] = match_window[k-1];
    match_window[0] = data;
    if (window_count < WINDOW_BYTES) window_count++;
    if (!section_matched && window_count >= span) begin
      ok = 1'b1;
      for (k = 0; k < span; k++)
        if (care_bits[k] && match_window[span-1-k] !== pat_bytes[k*8 +: 8]) ok = 1'b0;
      if (ok) begin
        start = {32'b0, offs} - 64'(span - 1);
        d = disp_reg[5] ? int'(disp_reg) - 64 : int'(disp_reg);
        // Resolve the little-endian rel32 only when it lies wholly inside the match
        if (d >= 0 && d + wbps_pkg::REL_FIELD_BYTES <= span) begin
          raw = {match_window[span-4-d], match_window[span-3-d],
                 match_window[span-2-d], match_window[span-1-d]};
          start = start + 64'(d) + 64'(wbps_pkg::REL_FIELD_BYTES) + {{32{raw[31]}}, raw};
        end
        off34 = start[wbps_pkg::RESULT_OFF_W-1:0];
        rep.found = 1'b1;
        rep.res_offset = off34;
        rep.res_address = base_reg +
          {{(wbps_pkg::ADDRESS_W-wbps_pkg::RESULT_OFF_W){off34[wbps_pkg::RESULT_OFF_W-1]}},
           off34};
        expected_reports = {expected_reports, rep};
        section_matched = 1'b1;
      end
    end
    if (last) begin
      if (!section_matched) begin
        rep.found = 1'b0;
        rep.res_offset = '0;
        rep.res_address = '0;
        expected_reports = {expected_reports, rep};
      end
      window_count = 0;
      section_matched = 1'b0;
    end
  endtask

  // Offer one byte request, with bursts and random gaps between them
  task automatic send_scan_byte(input logic [7:0] data, input logic [31:0] offs,
                                input logic first, input logic last);
    if (burst_left == 0) begin
      scan_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(7, 0) == 0) ? 200 : $urandom_range(16, 1);
    end
    scan_ch.valid         <= 1'b1;
    scan_ch.data_byte     <= data;
    scan_ch.byte_offset   <= offs;
    scan_ch.section_first <= first;
    scan_ch.section_last  <= last;
    do @(posedge clk); while (!scan_ch.ready);
    predict_scan_byte(data, offs, first, last);
    burst_left--;
  endtask

  task automatic stop_scan();
    scan_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Wait for every queued report, then let the pipeline settle
  task automatic wait_drain();
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold one register write request until accepted, then mirror it
  task automatic write_reg(input logic [wbps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [wbps_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      wbps_pkg::CFG_PATTERN_0:   pat_bytes[63:0]    = value;
      wbps_pkg::CFG_PATTERN_1:   pat_bytes[127:64]  = value;
      wbps_pkg::CFG_PATTERN_2:   pat_bytes[191:128] = value;
      wbps_pkg::CFG_PATTERN_3:   pat_bytes[255:192] = value;
      wbps_pkg::CFG_CARE_MASK:   care_bits = value[31:0];
      wbps_pkg::CFG_PATTERN_LEN: len_reg   = value[5:0];
      wbps_pkg::CFG_DISP_OFFSET: disp_reg  = value[5:0];
      wbps_pkg::CFG_IMAGE_BASE:  base_reg  = value;
      default: ;
    endcase
  endtask

  task automatic configure(input scan_setting_t s);
    write_reg(wbps_pkg::CFG_PATTERN_0, s.pattern[63:0]);
    write_reg(wbps_pkg::CFG_PATTERN_1, s.pattern[127:64]);
    write_reg(wbps_pkg::CFG_PATTERN_2, s.pattern[191:128]);
    write_reg(wbps_pkg::CFG_PATTERN_3, s.pattern[255:192]);
    write_reg(wbps_pkg::CFG_CARE_MASK, {32'b0, s.care});
    write_reg(wbps_pkg::CFG_PATTERN_LEN, {58'b0, s.length});
    write_reg(wbps_pkg::CFG_DISP_OFFSET, {58'b0, s.disp});
    write_reg(wbps_pkg::CFG_IMAGE_BASE, s.base);
    cfg_ch.valid <= 1'b0;
  endtask

  // Extremes first, then random settings biased towards relative mode
  function automatic scan_setting_t pick_setting(input int phase);
    scan_setting_t s;
    int            w;
    int            span;
    for (w = 0; w < wbps_pkg::PATTERN_WORDS; w++) s.pattern[w*64 +: 64] = {$urandom, $urandom};
    s.care   = $urandom;
    s.length = 6'($urandom_range(12, 1));
    s.disp   = 6'h3F;
    s.base   = {$urandom, $urandom};
    case (phase)
      0: begin
        s.length = 6'd32; s.care = '1; s.disp = 6'd28; s.base = '1;
      end
      1: begin
        s.length = 6'd63; s.care = '0; s.disp = 6'd31;
      end
      2: begin
        s.length = 6'd0; s.disp = 6'h20; s.base = '0;
      end
      3: begin
        s.length = 6'd1; s.disp = 6'd0; s.care = '1;
      end
      4: begin
        s.length = 6'd33; s.disp = 6'd29;
      end
      default: begin
        if ($urandom_range(3, 0) == 0) s.length = 6'($urandom_range(63, 0));
        case ($urandom_range(3, 0))
          0: s.care = '1;
          1: s.care &= $urandom;
          default: ;
        endcase
        span = span_of(s.length);
        if (span >= wbps_pkg::REL_FIELD_BYTES && $urandom_range(3, 0) != 0)
          s.disp = 6'($urandom_range(span - wbps_pkg::REL_FIELD_BYTES, 0));
        else if ($urandom_range(1, 0) == 0)
          s.disp = 6'($urandom_range(63, 0));
      end
    endcase
    return s;
  endfunction

  // One section of random bytes, often carrying the pattern, sometimes malformed
  task automatic send_random_section(output int sent);
    logic [7:0]  bytes_q [$];
    logic [31:0] offs;
    logic        first;
    logic        last;
    int          span;
    int          n;
    int          at;
    int          kind;
    int          copies;
    int          c;
    int          i;
    span = span_of(len_reg);
    case ($urandom_range(6, 0))
      0: n = $urandom_range(3, 1);
      1: n = $urandom_range(40, 1);
      default: n = span + $urandom_range(12, 0);
    endcase
    for (i = 0; i < n; i++) bytes_q = {bytes_q, 8'($urandom_range(255, 0))};
    copies = 0;
    if (n >= span && $urandom_range(9, 0) < 6) copies = ($urandom_range(3, 0) == 0) ? 2 : 1;
    for (c = 0; c < copies; c++) begin
      at = $urandom_range(n - span, 0);
      for (i = 0; i < span; i++)
        if (care_bits[i]) bytes_q[at+i] = pat_bytes[i*8 +: 8];
    end
    case ($urandom_range(3, 0))
      0: offs = 32'hFFFF_FFFF - $urandom_range(40, 0);
      1: offs = $urandom_range(40, 0);
      default: offs = $urandom;
    endcase
    // Mostly well-formed; a few drop or add section marks or jump the offset
    kind = $urandom_range(19, 0);
    for (i = 0; i < n; i++) begin
      first = (i == 0 && kind != 0) || (kind == 2 && i == n / 2 && i != 0);
      last  = (i == n - 1 && kind != 1) || (kind == 3 && i == n / 2 && i != n - 1);
      if (kind == 4 && i == n / 2) offs = $urandom;
      send_scan_byte(bytes_q[i], offs, first, last);
      offs = offs + 32'd1;
    end
    sent = n;
  endtask

  task automatic test_reset_defaults();
    send_scan_byte(8'h00, 32'h0000_0000, 1'b1, 1'b0);
    send_scan_byte(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_scan_byte(8'hA5, 32'h7FFF_FFFF, 1'b1, 1'b1);
    stop_scan();
    wait_drain();
  endtask

  task automatic test_wildcard_match();
    scan_setting_t s;
    s.pattern = '0;
    s.pattern[31:0] = 32'hEFBE_00DE;
    s.care   = 32'h0000_000D;
    s.length = 6'd4;
    s.disp   = 6'h3F;
    s.base   = 64'h0000_7FF6_0000_0000;
    configure(s);
    // Hit on the last byte: report only the hit
    send_scan_byte(8'h11, 32'h0000_1000, 1'b1, 1'b0);
    send_scan_byte(8'hDE, 32'h0000_1001, 1'b0, 1'b0);
    send_scan_byte(8'h22, 32'h0000_1002, 1'b0, 1'b0);
    send_scan_byte(8'hBE, 32'h0000_1003, 1'b0, 1'b0);
    send_scan_byte(8'hEF, 32'h0000_1004, 1'b0, 1'b1);
    // Miss, then a section with no first mark that must not see the old bytes
    send_scan_byte(8'hDE, 32'h0000_2000, 1'b1, 1'b0);
    send_scan_byte(8'h00, 32'h0000_2001, 1'b0, 1'b0);
    send_scan_byte(8'hBE, 32'h0000_2002, 1'b0, 1'b1);
    send_scan_byte(8'hEF, 32'h0000_2003, 1'b0, 1'b0);
    send_scan_byte(8'h44, 32'h0000_2004, 1'b0, 1'b0);
    send_scan_byte(8'h55, 32'h0000_2005, 1'b0, 1'b0);
    send_scan_byte(8'h66, 32'h0000_2006, 1'b0, 1'b1);
    stop_scan();
    wait_drain();
  endtask

  task automatic test_relative_target();
    scan_setting_t s;
    s.pattern = '0;
    s.pattern[7:0] = 8'hE8;
    s.care   = 32'h0000_0001;
    s.length = 6'd5;
    s.disp   = 6'd1;
    s.base   = '1;
    configure(s);
    // Most negative displacement, target lands below zero
    send_scan_byte(8'hE8, 32'h0000_0010, 1'b1, 1'b0);
    send_scan_byte(8'h00, 32'h0000_0011, 1'b0, 1'b0);
    send_scan_byte(8'h00, 32'h0000_0012, 1'b0, 1'b0);
    send_scan_byte(8'h00, 32'h0000_0013, 1'b0, 1'b0);
    send_scan_byte(8'h80, 32'h0000_0014, 1'b0, 1'b1);
    stop_scan();
    wait_drain();
  endtask

  task automatic test_zero_length();
    scan_setting_t s;
    s.pattern = '0;
    s.pattern[7:0] = 8'h5A;
    s.care   = '1;
    s.length = 6'd0;
    s.disp   = 6'd0;
    s.base   = 64'h0000_0000_0000_1000;
    configure(s);
    send_scan_byte(8'h5A, 32'h8000_0000, 1'b1, 1'b1);
    stop_scan();
    wait_drain();
  endtask

  task automatic test_random_sections();
    int phase;
    int count;
    int sent;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      configure(pick_setting(phase));
      count = 0;
      while (count < PHASE_BYTES) begin
        send_random_section(sent);
        count += sent;
      end
      stop_scan();
      wait_drain();
    end
  endtask

  task automatic test_result_backpressure();
    scan_setting_t s;
    int            i;
    s = pick_setting(RANDOM_PHASES);
    s.length = 6'd1;
    s.care   = '0;
    s.disp   = 6'h3F;
    configure(s);
    // Every one-byte section hits, so the result side fills while held off
    long_hold_req = 150;
    for (i = 0; i < 60; i++) send_scan_byte(8'($urandom_range(255, 0)), $urandom, 1'b1, 1'b1);
    stop_scan();
    wait_drain();
  endtask

  // Result side stalls on its own pattern, with a long hold-off on request
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold;
    int tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req > 0) begin
        hold = long_hold_req;
        long_hold_req = 0;
        result_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(3, 0);
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      tick++;
      case (mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= 1'($urandom_range(1, 0));
        2: result_ch.ready <= ($urandom_range(3, 0) == 0);
        default: result_ch.ready <= ((tick % 7) < 4);
      endcase
    end
  end

  // Compare each accepted report with the oldest expectation
  always @(posedge clk) begin : report_check
    scan_report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report: found %0b offset %0h address %0h", result_ch.found,
               result_ch.resolved_offset, result_ch.resolved_address);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        if (result_ch.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, result_ch.found);
          fail_count++;
        end
        if (result_ch.resolved_offset !== want.res_offset) begin
          $error("resolved_offset: expected %0h, got %0h", want.res_offset,
                 result_ch.resolved_offset);
          fail_count++;
        end
        if (result_ch.resolved_address !== want.res_address) begin
          $error("resolved_address: expected %0h, got %0h", want.res_address,
                 result_ch.resolved_address);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst                   <= 1'b1;
    scan_ch.valid         <= 1'b0;
    scan_ch.data_byte     <= '0;
    scan_ch.byte_offset   <= '0;
    scan_ch.section_first <= 1'b0;
    scan_ch.section_last  <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= '0;
    cfg_ch.data           <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_wildcard_match();
    test_relative_target();
    test_zero_length();
    test_random_sections();
    test_result_backpressure();
    wait_drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== wildcard_byte_pattern_scan.f =====
rtl/core/wbps_pkg.sv
rtl/core/wbps_if.sv
rtl/core/wbps_align.sv
rtl/core/wildcard_byte_pattern_scan.sv
tb/tb_top.sv
